// ----- sv/plane_segment_merge_table_macros.svh -----
// Assertion macros of the plane segment merge table top level.
`ifndef PLANE_SEGMENT_MERGE_TABLE_MACROS_SVH
`define PLANE_SEGMENT_MERGE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PSMT_ASSERT_IMPLY(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("psmt assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PSMT_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("psmt assertion failed");

`endif

// ----- sv/psmt_pkg.sv -----
// Types and constants of the plane segment merge table.
package psmt_pkg;

	localparam int ADDR_W = 4;

	// Register indexes on paddr[3:2].
	localparam logic [1:0] REG_ANGLE_TOL  = 2'd0;
	localparam logic [1:0] REG_NORMAL_GAP = 2'd1;
	localparam logic [1:0] REG_PLANE_GAP  = 2'd2;
	localparam logic [1:0] REG_MIN_AREA   = 2'd3;

	localparam logic [14:0] ANGLE_TOL_RST  = 15'd1638;
	localparam logic [22:0] NORMAL_GAP_RST = 23'd256;
	localparam logic [22:0] PLANE_GAP_RST  = 23'd1536;
	localparam logic [31:0] MIN_AREA_RST   = 32'd262144;

	typedef logic [2:0][23:0] vec_t;
	typedef logic [2:0][15:0] nvec_t;

	typedef struct packed {
		vec_t  centre;
		nvec_t normal;
	} geo_t;

	typedef struct packed {
		vec_t lo;
		vec_t hi;
	} box_t;

	typedef struct packed {
		logic [14:0] angle_tol;
		logic [22:0] normal_gap;
		logic [22:0] plane_gap;
		logic [31:0] area_floor;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} match_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BOX_RD,
		ST_UPDATE,
		ST_SORT,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

// ----- sv/psmt_cfg.sv -----
// APB-style configuration registers of the plane segment merge table.
module psmt_cfg import psmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_beat;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_beat = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// Register writes; values are masked to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_tol  <= ANGLE_TOL_RST;
			cfg_q.normal_gap <= NORMAL_GAP_RST;
			cfg_q.plane_gap  <= PLANE_GAP_RST;
			cfg_q.area_floor <= MIN_AREA_RST;
		end else if (wr_beat) begin
			case (reg_idx)
				REG_ANGLE_TOL:  cfg_q.angle_tol  <= pwdata[14:0];
				REG_NORMAL_GAP: cfg_q.normal_gap <= pwdata[22:0];
				REG_PLANE_GAP:  cfg_q.plane_gap  <= pwdata[22:0];
				REG_MIN_AREA:   cfg_q.area_floor <= pwdata;
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_ANGLE_TOL:  prdata = {17'd0, cfg_q.angle_tol};
			REG_NORMAL_GAP: prdata = {9'd0, cfg_q.normal_gap};
			REG_PLANE_GAP:  prdata = {9'd0, cfg_q.plane_gap};
			REG_MIN_AREA:   prdata = cfg_q.area_floor;
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/psmt_match.sv -----
// Plane geometry memory and the pipelined three-way plane match test.
module psmt_match import psmt_pkg::*; #(
	parameter  int DEPTH = 256,
	localparam int IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  geo_t          wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic          flush,
	input  vec_t          seg_centre,
	input  nvec_t         seg_normal,
	input  cfg_t          cfg,
	output match_t        res,
	output logic [IW-1:0] res_index
);

	geo_t geo_mem [DEPTH];

	geo_t          geo_s1;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;

	logic signed [24:0] d_c  [3];
	logic signed [31:0] nm_c [3];
	logic signed [40:0] dm_c [3];
	logic signed [24:0] d_s2 [3];
	logic signed [31:0] nm_s2 [3];
	logic signed [40:0] dm_s2 [3];
	nvec_t              m_s2;

	logic signed [33:0] dot_c;
	logic        [33:0] abs_dot_c;
	logic signed [42:0] t_c;
	logic        [42:0] abs_t_c;
	logic               ok_c;
	logic signed [58:0] tm_c [3];
	logic signed [58:0] tm_s3 [3];
	logic signed [24:0] d_s3 [3];
	logic               ok_s3;

	logic signed [45:0] e_c  [3];
	logic signed [45:0] rr_c [3];
	logic signed [65:0] sq_c [3];
	logic        [65:0] sq_s4 [3];
	logic        [45:0] gsq_s4;
	logic               ok_s4;

	logic [67:0] sum_c;
	logic        hit_s5;

	// Geometry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			geo_mem[wr_addr] <= wr_data;
		if (rd_en)
			geo_s1 <= geo_mem[rd_addr];
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
	end

	// Valid chain; a flush drops everything still in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= rd_en && !flush;
			v_s2 <= v_s1 && !flush;
			v_s3 <= v_s2 && !flush;
			v_s4 <= v_s3 && !flush;
			v_s5 <= v_s4 && !flush;
		end
	end

	// Stage two: centroid offset and the per-axis products.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i]  = {seg_centre[i][23], seg_centre[i]}
				- {geo_s1.centre[i][23], geo_s1.centre[i]};
			nm_c[i] = $signed(seg_normal[i]) * $signed(geo_s1.normal[i]);
			dm_c[i] = d_c[i] * $signed(geo_s1.normal[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s2[i]  <= d_c[i];
			nm_s2[i] <= nm_c[i];
			dm_s2[i] <= dm_c[i];
		end
		m_s2 <= geo_s1.normal;
	end

	// Stage three: angle and normal-gap tests, then t times the stored normal.
	always_comb begin
		dot_c     = 34'(nm_s2[0]) + 34'(nm_s2[1]) + 34'(nm_s2[2]);
		t_c       = 43'(dm_s2[0]) + 43'(dm_s2[1]) + 43'(dm_s2[2]);
		abs_dot_c = dot_c[33] ? 34'(-dot_c) : 34'(dot_c);
		abs_t_c   = t_c[42] ? 43'(-t_c) : 43'(t_c);
		ok_c = ((36'sd268435456 - $signed({2'b00, abs_dot_c}))
				< $signed({7'd0, cfg.angle_tol, 14'd0}))
			&& (abs_t_c < {6'd0, cfg.normal_gap, 14'd0});
		for (int i = 0; i < 3; i++)
			tm_c[i] = t_c * $signed(m_s2[i]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			tm_s3[i] <= tm_c[i];
			d_s3[i]  <= d_s2[i];
		end
		ok_s3 <= ok_c;
	end

	// Stage four: in-plane offset, rounded to 1/256 m, and squared.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_c[i]  = $signed({{7{d_s3[i][24]}}, d_s3[i], 14'd0}) - 46'(tm_s3[i] >>> 14);
			rr_c[i] = (e_c[i] + 46'sd8192) >>> 14;
			sq_c[i] = $signed(rr_c[i][32:0]) * $signed(rr_c[i][32:0]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s4[i] <= $unsigned(sq_c[i]);
		gsq_s4 <= 46'(cfg.plane_gap * cfg.plane_gap);
		ok_s4  <= ok_s3;
	end

	// Stage five: plane-gap test on the sum of squares.
	assign sum_c = 68'(sq_s4[0]) + 68'(sq_s4[1]) + 68'(sq_s4[2]);

	always_ff @(posedge clk) begin
		hit_s5 <= ok_s4 && (sum_c < 68'(gsq_s4));
	end

	assign res.valid = v_s5;
	assign res.hit   = hit_s5;
	assign res_index = idx_s5;

endmodule

// ----- sv/psmt_box.sv -----
// Plane box memory, box merge and the minimum-area test.
module psmt_box import psmt_pkg::*; #(
	parameter  int DEPTH = 256,
	localparam int IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic          upd_en,
	input  logic [IW-1:0] upd_addr,
	input  logic          merge,
	input  box_t          seg_box,
	input  logic [31:0]   area_floor,
	output box_t          upd_box,
	output logic          area_ok
);

	box_t box_mem [DEPTH];

	box_t               box_s1;
	box_t               new_box;
	box_t               upd_q;
	logic signed [24:0] side_c [3];
	logic signed [24:0] a0, a1, b1, b2, c1;
	logic signed [24:0] mid_q, top_q;
	logic signed [49:0] prod_q;
	logic        [49:0] abs_prod;

	// The segment box, merged when merge is set: elementwise min of minima and max of maxima.
	always_comb begin
		new_box = seg_box;
		if (merge) begin
			for (int i = 0; i < 3; i++) begin
				if ($signed(box_s1.lo[i]) < $signed(seg_box.lo[i]))
					new_box.lo[i] = box_s1.lo[i];
				if ($signed(box_s1.hi[i]) > $signed(seg_box.hi[i]))
					new_box.hi[i] = box_s1.hi[i];
			end
		end
	end

	// Box memory, read ahead of the write of the same entry.
	always_ff @(posedge clk) begin
		if (rd_en)
			box_s1 <= box_mem[rd_addr];
		if (upd_en) begin
			box_mem[upd_addr] <= new_box;
			upd_q             <= new_box;
		end
	end

	// Three signed sides through a three-step sorting network; only the
	// middle and the largest side are kept.
	always_comb begin
		for (int i = 0; i < 3; i++)
			side_c[i] = {upd_q.hi[i][23], upd_q.hi[i]} - {upd_q.lo[i][23], upd_q.lo[i]};
		a0 = (side_c[0] > side_c[1]) ? side_c[1] : side_c[0];
		a1 = (side_c[0] > side_c[1]) ? side_c[0] : side_c[1];
		b1 = (a1 > side_c[2]) ? side_c[2] : a1;
		b2 = (a1 > side_c[2]) ? a1 : side_c[2];
		c1 = (a0 > b1) ? a0 : b1;
	end

	// Sort then multiply, one register after each.
	always_ff @(posedge clk) begin
		mid_q  <= c1;
		top_q  <= b2;
		prod_q <= mid_q * top_q;
	end

	assign abs_prod = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
	assign area_ok  = abs_prod >= {18'd0, area_floor};
	assign upd_box  = upd_q;

endmodule

// ----- sv/plane_segment_merge_table.sv -----
// Top level of the plane segment merge table: control sequencer and ports.
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall  | segment centroid, normal and box
//  out     | output    | out_valid/out_stall| plane index, flags, updated box
//  cfg     | input     | psel/penable/pwrite| one 32 bit register write
//
// One segment at a time. A match scan issues one stored plane read per cycle,
// and each verdict returns through the match pipeline after its read is issued.
// Reset clears the plane count and the registers; the memories are not cleared.
// A stalled output holds the result, and the next segment is already accepted.
module plane_segment_merge_table import psmt_pkg::*; #(
	parameter int MAX_PLANES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [23:0]       centre_x,
	input  logic [23:0]       centre_y,
	input  logic [23:0]       centre_z,
	input  logic [15:0]       norm_x,
	input  logic [15:0]       norm_y,
	input  logic [15:0]       norm_z,
	input  logic [23:0]       low_x,
	input  logic [23:0]       high_x,
	input  logic [23:0]       low_y,
	input  logic [23:0]       high_y,
	input  logic [23:0]       low_z,
	input  logic [23:0]       high_z,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        plane_index,
	output logic              merged,
	output logic              table_full,
	output logic              area_ok,
	output logic [23:0]       out_low_x,
	output logic [23:0]       out_high_x,
	output logic [23:0]       out_low_y,
	output logic [23:0]       out_high_y,
	output logic [23:0]       out_low_z,
	output logic [23:0]       out_high_z,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	`include "plane_segment_merge_table_macros.svh"

	localparam int IW   = $clog2(MAX_PLANES);
	localparam int CNTW = $clog2(MAX_PLANES + 1);

	cfg_t          cfg;
	match_t        res;
	logic [IW-1:0] res_index;

	state_t state_q, state_d;

	vec_t  seg_centre_q;
	nvec_t seg_normal_q;
	box_t  seg_box_q;
	geo_t  wr_geo;

	logic [CNTW-1:0] count_q, iss_q, ret_q;
	logic [IW-1:0]   hit_q;
	logic            merge_q, full_q;

	logic in_beat, slot_free, found, last_ret, scan_rd, box_rd, upd_en, geo_wr, load_out;
	box_t upd_box;
	logic box_area_ok;

	logic        out_valid_q;
	logic [7:0]  plane_index_q;
	logic        merged_q, table_full_q, area_ok_q;
	box_t        out_box_q;

	psmt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign wr_geo.centre = seg_centre_q;
	assign wr_geo.normal = seg_normal_q;

	psmt_match #(.DEPTH(MAX_PLANES)) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (geo_wr),
		.wr_addr   (hit_q),
		.wr_data   (wr_geo),
		.rd_en     (scan_rd),
		.rd_addr   (iss_q[IW-1:0]),
		.flush     (found),
		.seg_centre(seg_centre_q),
		.seg_normal(seg_normal_q),
		.cfg       (cfg),
		.res       (res),
		.res_index (res_index)
	);

	psmt_box #(.DEPTH(MAX_PLANES)) u_box (
		.clk       (clk),
		.rd_en     (box_rd),
		.rd_addr   (hit_q),
		.upd_en    (upd_en),
		.upd_addr  (hit_q),
		.merge     (merge_q),
		.seg_box   (seg_box_q),
		.area_floor(cfg.area_floor),
		.upd_box   (upd_box),
		.area_ok   (box_area_ok)
	);

	assign in_beat   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign found     = (state_q == ST_SCAN) && res.valid && res.hit;
	assign last_ret  = CNTW'(ret_q + 1'b1) == count_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_beat)
					state_d = (count_q == '0) ? ST_UPDATE : ST_SCAN;
			ST_SCAN:
				if (found)
					state_d = ST_BOX_RD;
				else if (res.valid && last_ret)
					state_d = (count_q < CNTW'(MAX_PLANES)) ? ST_UPDATE : ST_DONE;
			ST_BOX_RD: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_SORT;
			ST_SORT:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_DONE;
			ST_DONE:
				if (slot_free)
					state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = 1'b1;
		scan_rd  = 1'b0;
		box_rd   = 1'b0;
		upd_en   = 1'b0;
		geo_wr   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN:   scan_rd  = (iss_q < count_q) && !found;
			ST_BOX_RD: box_rd   = 1'b1;
			ST_UPDATE: begin
				upd_en = 1'b1;
				geo_wr = !merge_q;
			end
			ST_DONE:   load_out = slot_free;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Segment capture on the input beat.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			seg_centre_q <= {centre_z, centre_y, centre_x};
			seg_normal_q <= {norm_z, norm_y, norm_x};
			seg_box_q.lo <= {low_z, low_y, low_x};
			seg_box_q.hi <= {high_z, high_y, high_x};
		end
	end

	// Scan counters, match outcome and plane count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iss_q   <= '0;
			ret_q   <= '0;
			hit_q   <= '0;
			merge_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (in_beat) begin
				iss_q   <= '0;
				ret_q   <= '0;
				merge_q <= 1'b0;
				full_q  <= 1'b0;
				hit_q   <= count_q[IW-1:0];
			end
			if (scan_rd)
				iss_q <= CNTW'(iss_q + 1'b1);
			if ((state_q == ST_SCAN) && res.valid)
				ret_q <= CNTW'(ret_q + 1'b1);
			if (found) begin
				hit_q   <= res_index;
				merge_q <= 1'b1;
			end else if ((state_q == ST_SCAN) && res.valid && last_ret
					&& !(count_q < CNTW'(MAX_PLANES))) begin
				full_q <= 1'b1;
			end
			if (geo_wr)
				count_q <= CNTW'(count_q + 1'b1);
		end
	end

	// Output register; a full table gives zeros except its flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			plane_index_q <= full_q ? 8'd0 : 8'(hit_q);
			merged_q      <= merge_q && !full_q;
			table_full_q  <= full_q;
			area_ok_q     <= box_area_ok && !full_q;
			out_box_q     <= full_q ? '0 : upd_box;
		end
	end

	assign out_valid   = out_valid_q;
	assign plane_index = plane_index_q;
	assign merged      = merged_q;
	assign table_full  = table_full_q;
	assign area_ok     = area_ok_q;
	assign out_low_x   = out_box_q.lo[0];
	assign out_low_y   = out_box_q.lo[1];
	assign out_low_z   = out_box_q.lo[2];
	assign out_high_x  = out_box_q.hi[0];
	assign out_high_y  = out_box_q.hi[1];
	assign out_high_z  = out_box_q.hi[2];

	// The plane count never passes the table depth.
	`PSMT_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNTW'(MAX_PLANES))
	// Match results only arrive during a scan, so a flush really drains them.
	`PSMT_ASSERT_IMPLY(a_res_in_scan, res.valid, state_q == ST_SCAN)
	// A dropped segment is never reported as merged.
	`PSMT_ASSERT_IMPLY(a_full_not_merged, out_valid_q && table_full_q, !merged_q)
	// An accepted segment always starts the sequencer.
	`PSMT_ASSERT_NEXT(a_beat_starts, in_beat, state_q != ST_IDLE)

endmodule
